// File: rtl/rcz_pkg.sv
package rcz_pkg;

    // Pixel format
    localparam int CHANNEL_BITS = 8;
    localparam int NUM_CHANNELS = 3;
    localparam int CH_RED       = 2;
    localparam int CH_GREEN     = 1;
    localparam int CH_BLUE      = 0;

    // Frame geometry
    localparam int DEFAULT_MAX_WIDTH = 1024;
    localparam int MAX_HEIGHT        = 1024;
    localparam int ROW_BITS          = 11;
    localparam int GEOM_BITS         = 11;
    localparam logic [GEOM_BITS-1:0] RESET_WIDTH  = 11'd640;
    localparam logic [GEOM_BITS-1:0] RESET_HEIGHT = 11'd480;

    // Configuration port
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 11;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_KERNEL_MODE  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_HEIGHT = 2'd2;

    // Filter arithmetic
    localparam int SUM_BITS   = 12;   // sum of nine channel values
    localparam int NUM_BITS   = 14;   // signed numerator for the divide by 9
    localparam int DIVN_BITS  = 13;   // rounded numerator, always below 4600
    localparam int PROD_BITS  = 26;
    localparam logic [DIVN_BITS-1:0] DIV9_RECIP = 13'd7282;  // ceil(2^16 / 9)
    localparam int DIV9_SHIFT = 16;
    localparam logic [DIVN_BITS-1:0] DIV9_ROUND = 13'd4;

    typedef enum logic [1:0] {
        KM_IDENTITY = 2'd0,
        KM_MEAN     = 2'd1,
        KM_RIGHT    = 2'd2,
        KM_SHARPEN  = 2'd3
    } kmode_t;

    // One pixel, red in the top lane
    typedef logic [NUM_CHANNELS-1:0][CHANNEL_BITS-1:0] rgb_t;

    // Output position info for one beat
    typedef struct packed {
        logic emit;
        logic last;
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
    } pos_flags_t;

    // Round to nearest divide by 9, clamped to 0..255
    function automatic logic [CHANNEL_BITS-1:0] div9_sat(input logic signed [NUM_BITS-1:0] num);
        logic [DIVN_BITS-1:0] n;
        logic [PROD_BITS-1:0] prod;
        logic [PROD_BITS-DIV9_SHIFT-1:0] q;
        logic [CHANNEL_BITS-1:0] res;
        n    = num[DIVN_BITS-1:0] + DIV9_ROUND;
        prod = PROD_BITS'(n) * PROD_BITS'(DIV9_RECIP);
        q    = prod[PROD_BITS-1:DIV9_SHIFT];
        if (num <= 0)
        begin
            res = '0;
        end
        else if (q > (PROD_BITS-DIV9_SHIFT)'(255))
        begin
            res = '1;
        end
        else
        begin
            res = q[CHANNEL_BITS-1:0];
        end
        return res;
    endfunction

endpackage

// File: rtl/rcz_line_buf.sv
module rcz_line_buf
    import rcz_pkg::*;
#(
    parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
    input  logic                         wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
    input  rgb_t                         wr_pix,
    output rgb_t                         top_pix,
    output rgb_t                         mid_pix
);

    localparam int AW = $clog2(MAX_WIDTH);

    // Row above (a) and two rows above (b) the input row
    rgb_t mem_a [MAX_WIDTH];
    rgb_t mem_b [MAX_WIDTH];

    rgb_t raw_a_reg;
    rgb_t raw_b_reg;
    rgb_t byp_a_reg;
    rgb_t byp_b_reg;
    logic byp_reg;

    // Read data, with the write of the same edge forwarded
    assign mid_pix = byp_reg ? byp_a_reg : raw_a_reg;
    assign top_pix = byp_reg ? byp_b_reg : raw_b_reg;

    // Line stores: the pixel goes to a, the old a entry moves down to b
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_a[wr_addr] <= wr_pix;
            mem_b[wr_addr] <= mid_pix;
        end
        if (rd_en)
        begin
            raw_a_reg <= mem_a[rd_addr];
            raw_b_reg <= mem_b[rd_addr];
        end
    end

    // Forwarding path for a read that hits the column being written
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            byp_a_reg <= wr_pix;
            byp_b_reg <= mid_pix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            byp_reg <= wr_en && (wr_addr == rd_addr[AW-1:0]);
        end
    end

endmodule

// File: rtl/rcz_filter.sv
module rcz_filter
    import rcz_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load,
    output logic                    ready,
    input  rgb_t                    top_pix,
    input  rgb_t                    mid_pix,
    input  rgb_t                    new_pix,
    input  pos_flags_t              flags,
    input  kmode_t                  kernel_mode,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [CHANNEL_BITS-1:0] red_out,
    output logic [CHANNEL_BITS-1:0] green_out,
    output logic [CHANNEL_BITS-1:0] blue_out,
    output logic                    frame_end
);

    // Window stage
    rgb_t       window_reg [3][3];
    pos_flags_t s2_flags_reg;
    logic       s2_valid_reg;

    // Numerator stage
    logic signed [NUM_BITS-1:0] s3_num_reg [NUM_CHANNELS];
    logic                       s3_div_reg;
    logic                       s3_last_reg;
    logic                       s3_valid_reg;

    // Result stage
    logic [CHANNEL_BITS-1:0] out_pix_reg [NUM_CHANNELS];
    logic                    out_last_reg;
    logic                    out_valid_reg;

    logic s4_free;
    logic s3_move;
    logic s3_free;
    logic s2_move;
    logic s2_free;

    rgb_t                       masked [3][3];
    logic [2:0]                 row_ok;
    logic [2:0]                 col_ok;
    logic [SUM_BITS-1:0]        row_sum [NUM_CHANNELS][3];
    logic [SUM_BITS-1:0]        sum [NUM_CHANNELS];
    logic [DIVN_BITS-1:0]       center18 [NUM_CHANNELS];
    logic signed [NUM_BITS-1:0] num_next [NUM_CHANNELS];
    logic                       div_next;

    // Stage handshakes; a beat without an output leaves at the window stage
    assign s4_free = !out_valid_reg || out_ready;
    assign s3_move = s3_valid_reg && s4_free;
    assign s3_free = !s3_valid_reg || s3_move;
    assign s2_move = s2_valid_reg && (!s2_flags_reg.emit || s3_free);
    assign s2_free = !s2_valid_reg || s2_move;
    assign ready   = s2_free;

    // Window shift: the new column enters on the right
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int r = 0; r < 3; r++)
            begin
                window_reg[r][0] <= window_reg[r][1];
                window_reg[r][1] <= window_reg[r][2];
            end
            window_reg[0][2] <= top_pix;
            window_reg[1][2] <= mid_pix;
            window_reg[2][2] <= new_pix;
            s2_flags_reg     <= flags;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_free)
        begin
            s2_valid_reg <= load;
        end
    end

    // Zero padding at the frame border
    always_comb
    begin
        row_ok = {s2_flags_reg.bot_ok, 1'b1, s2_flags_reg.top_ok};
        col_ok = {s2_flags_reg.right_ok, 1'b1, s2_flags_reg.left_ok};
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                masked[r][c] = (row_ok[r] && col_ok[c]) ? window_reg[r][c] : '0;
            end
        end
    end

    // Per channel kernel sums and numerator select
    always_comb
    begin
        div_next = (kernel_mode == KM_MEAN) || (kernel_mode == KM_SHARPEN);
        for (int ch = 0; ch < NUM_CHANNELS; ch++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                row_sum[ch][r] = SUM_BITS'(masked[r][0][ch]) + SUM_BITS'(masked[r][1][ch])
                               + SUM_BITS'(masked[r][2][ch]);
            end
            sum[ch]      = row_sum[ch][0] + row_sum[ch][1] + row_sum[ch][2];
            center18[ch] = {1'b0, masked[1][1][ch], 4'b0000}
                         + {4'b0000, masked[1][1][ch], 1'b0};
            unique case (kernel_mode)
                KM_IDENTITY: num_next[ch] = $signed(NUM_BITS'(masked[1][1][ch]));
                KM_MEAN:     num_next[ch] = $signed(NUM_BITS'(sum[ch]));
                KM_RIGHT:    num_next[ch] = $signed(NUM_BITS'(masked[1][2][ch]));
                KM_SHARPEN:  num_next[ch] = $signed({1'b0, center18[ch]})
                                          - $signed({2'b00, sum[ch]});
                default:     num_next[ch] = '0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_move && s2_flags_reg.emit)
        begin
            for (int ch = 0; ch < NUM_CHANNELS; ch++)
            begin
                s3_num_reg[ch] <= num_next[ch];
            end
            s3_div_reg  <= div_next;
            s3_last_reg <= s2_flags_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s3_free)
        begin
            s3_valid_reg <= s2_move && s2_flags_reg.emit;
        end
    end

    // Divide, round and clamp into the output register
    always_ff @(posedge clk)
    begin
        if (s3_move)
        begin
            for (int ch = 0; ch < NUM_CHANNELS; ch++)
            begin
                out_pix_reg[ch] <= s3_div_reg ? div9_sat(s3_num_reg[ch])
                                              : s3_num_reg[ch][CHANNEL_BITS-1:0];
            end
            out_last_reg <= s3_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s4_free)
        begin
            out_valid_reg <= s3_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign red_out   = out_pix_reg[CH_RED];
    assign green_out = out_pix_reg[CH_GREEN];
    assign blue_out  = out_pix_reg[CH_BLUE];
    assign frame_end = out_last_reg;

endmodule

// File: rtl/rgb_conv3x3_zero_pad.sv
// Streaming 3x3 filter for RGB pixels in raster order, zero padded at the
// frame border. Kernel: identity, 3x3 mean, right neighbor or sharpen.
// Input channel: in_valid/in_ready, one beat per pixel (action 0) or drain
// beat (action 1, a black pixel). Output channel: out_valid/out_ready, one
// beat per filtered pixel, frame_end set on the last pixel of the frame.
// Config channel: cfg_valid/cfg_ready, always ready; index 0 kernel_mode,
// 1 image_width, 2 image_height. A width or height write restarts the frame.
// Write config only while the block is empty.
// Throughput: one beat per cycle in both directions while out_ready is high.
// An output pixel belongs to the input beat W+1 beats earlier, so W+1
// drain beats flush a frame. Pipeline: input/line store read, window,
// kernel sum, divide and clamp into the output register.
// Reset: positions cleared, kernel identity, 640x480. The line stores are
// not cleared; the border padding hides anything stale.
// With out_ready low the result register holds, the pipeline fills and
// in_ready drops once the kernel sum, window and input stages are full.
module rgb_conv3x3_zero_pad
    import rcz_pkg::*;
#(
    parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      action,
    input  logic [CHANNEL_BITS-1:0]   red_in,
    input  logic [CHANNEL_BITS-1:0]   green_in,
    input  logic [CHANNEL_BITS-1:0]   blue_in,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [CHANNEL_BITS-1:0]   red_out,
    output logic [CHANNEL_BITS-1:0]   green_out,
    output logic [CHANNEL_BITS-1:0]   blue_out,
    output logic                      frame_end,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WB = $clog2(MAX_WIDTH + 1);

    // Configuration
    kmode_t               kernel_mode_reg;
    logic [GEOM_BITS-1:0] image_width_reg;
    logic [GEOM_BITS-1:0] image_height_reg;

    // Input position
    logic [AW-1:0]       in_column_reg;
    logic [ROW_BITS-1:0] in_row_reg;
    logic [AW-1:0]       in_column_next;
    logic [ROW_BITS-1:0] in_row_next;

    // Input stage
    logic       s1_valid_reg;
    rgb_t       s1_pix_reg;
    logic [AW-1:0] s1_col_reg;
    pos_flags_t s1_flags_reg;

    logic       cfg_fire;
    logic       geom_write;
    logic       in_fire;
    logic       s1_move;
    logic       s2_free;
    logic [31:0] w_full;
    logic [WB-1:0] eff_w;
    logic [ROW_BITS-1:0] eff_h;
    logic       col_zero;
    logic       row_wrap;
    logic [WB-1:0] col_inc;
    rgb_t       pix_next;
    pos_flags_t flags_next;
    rgb_t       top_pix;
    rgb_t       mid_pix;

    assign cfg_ready  = 1'b1;
    assign cfg_fire   = cfg_valid && cfg_ready;
    assign geom_write = cfg_fire
                     && ((cfg_index == CFG_IMAGE_WIDTH) || (cfg_index == CFG_IMAGE_HEIGHT));

    // Configuration registers; an index past the list is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_mode_reg  <= KM_IDENTITY;
            image_width_reg  <= RESET_WIDTH;
            image_height_reg <= RESET_HEIGHT;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index)
                CFG_KERNEL_MODE:  kernel_mode_reg  <= kmode_t'(cfg_data[1:0]);
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[GEOM_BITS-1:0];
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data[GEOM_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // Effective geometry, clamped to the supported range
    always_comb
    begin
        w_full = 32'(image_width_reg);
        if (w_full == 32'd0)
        begin
            w_full = 32'd1;
        end
        else if (w_full > 32'(MAX_WIDTH))
        begin
            w_full = 32'(MAX_WIDTH);
        end
        eff_w = w_full[WB-1:0];

        if (image_height_reg == '0)
        begin
            eff_h = ROW_BITS'(1);
        end
        else if (image_height_reg > ROW_BITS'(MAX_HEIGHT))
        begin
            eff_h = ROW_BITS'(MAX_HEIGHT);
        end
        else
        begin
            eff_h = image_height_reg;
        end
    end

    // Input handshake through the input stage
    assign s1_move  = s1_valid_reg && s2_free;
    assign in_ready = !s1_valid_reg || s1_move;
    assign in_fire  = in_valid && in_ready;

    // Pixel, output position and border flags for the incoming beat
    always_comb
    begin
        col_zero = (in_column_reg == '0);

        if (action || (in_row_reg >= eff_h))
        begin
            pix_next = '0;
        end
        else
        begin
            pix_next[CH_RED]   = red_in;
            pix_next[CH_GREEN] = green_in;
            pix_next[CH_BLUE]  = blue_in;
        end

        flags_next.emit = (in_row_reg >= ROW_BITS'(2))
                       || ((in_row_reg == ROW_BITS'(1)) && !col_zero);
        if (!col_zero)
        begin
            // output at the row above, one column to the left
            flags_next.top_ok   = in_row_reg >= ROW_BITS'(2);
            flags_next.bot_ok   = in_row_reg < eff_h;
            flags_next.left_ok  = in_column_reg > AW'(1);
            flags_next.right_ok = 1'b1;
            flags_next.last     = 1'b0;
        end
        else
        begin
            // output at the last column, two rows above
            flags_next.top_ok   = in_row_reg >= ROW_BITS'(3);
            flags_next.bot_ok   = in_row_reg <= eff_h;
            flags_next.left_ok  = eff_w > WB'(1);
            flags_next.right_ok = 1'b0;
            flags_next.last     = flags_next.emit && (in_row_reg == eff_h + ROW_BITS'(1));
        end

        col_inc  = WB'(in_column_reg) + WB'(1);
        row_wrap = col_inc >= eff_w;
        if (flags_next.last)
        begin
            in_column_next = '0;
            in_row_next    = '0;
        end
        else if (row_wrap)
        begin
            in_column_next = '0;
            in_row_next    = (in_row_reg == '1) ? in_row_reg : in_row_reg + ROW_BITS'(1);
        end
        else
        begin
            in_column_next = in_column_reg + AW'(1);
            in_row_next    = in_row_reg;
        end
    end

    // Position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_column_reg <= '0;
            in_row_reg    <= '0;
        end
        else if (geom_write)
        begin
            in_column_reg <= '0;
            in_row_reg    <= '0;
        end
        else if (in_fire)
        begin
            in_column_reg <= in_column_next;
            in_row_reg    <= in_row_next;
        end
    end

    // Input stage register
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_pix_reg   <= pix_next;
            s1_col_reg   <= in_column_reg;
            s1_flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    rcz_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_fire),
        .rd_addr (in_column_reg),
        .wr_en   (s1_move),
        .wr_addr (s1_col_reg),
        .wr_pix  (s1_pix_reg),
        .top_pix (top_pix),
        .mid_pix (mid_pix)
    );

    rcz_filter u_filter (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (s1_move),
        .ready       (s2_free),
        .top_pix     (top_pix),
        .mid_pix     (mid_pix),
        .new_pix     (s1_pix_reg),
        .flags       (s1_flags_reg),
        .kernel_mode (kernel_mode_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .red_out     (red_out),
        .green_out   (green_out),
        .blue_out    (blue_out),
        .frame_end   (frame_end)
    );

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import rcz_pkg::*;

    // Index past the register list, writes to it must be dropped
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_INDEX = 2'd3;
    localparam int RAND_BEATS    = 900;
    localparam int EXT_BEATS     = 40;
    localparam int SETTLE_CYCLES = 8;
    localparam int SHOW_ERRORS   = 10;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       fe;
    } pix_res_t;

    typedef enum logic { ROW_BEAT, ROW_REG } row_kind_t;

    typedef struct packed {
        row_kind_t                 kind;
        logic                      act;
        logic [7:0]                red;
        logic [7:0]                green;
        logic [7:0]                blue;
        logic [CFG_INDEX_BITS-1:0] idx;
        logic [CFG_DATA_BITS-1:0]  data;
        logic                      chk;
        pix_res_t                  want;
    } plan_row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic                      action;
    logic [CHANNEL_BITS-1:0]   red_in;
    logic [CHANNEL_BITS-1:0]   green_in;
    logic [CHANNEL_BITS-1:0]   blue_in;
    logic                      out_valid;
    logic                      out_ready;
    logic [CHANNEL_BITS-1:0]   red_out;
    logic [CHANNEL_BITS-1:0]   green_out;
    logic [CHANNEL_BITS-1:0]   blue_out;
    logic                      frame_end;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    rgb_conv3x3_zero_pad u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .frame_end (frame_end),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Filter model state
    logic [23:0]      line_a [1024];
    logic [23:0]      line_b [1024];
    logic [8:0][23:0] win;
    int unsigned      pos_col;
    int unsigned      pos_row;
    int unsigned      pos_cnt;
    kmode_t           cur_mode;
    logic [10:0]      cur_width;
    logic [10:0]      cur_height;

    pix_res_t  pixel_q [$];
    plan_row_t dir_plan [$];

    bit          no_idle;
    int          err_cnt;
    int unsigned n_in;
    int unsigned n_out;
    int unsigned n_frames;
    int unsigned n_cfg;

    int unsigned ext_w [4] = '{0, 2047, 1, 3};
    int unsigned ext_h [4] = '{2, 1, 2047, 0};

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case a handshake hangs
    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic note_fail(input string msg);
        err_cnt++;
        if (err_cnt <= SHOW_ERRORS)
        begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
    endtask

    function automatic int unsigned geom_eff(input logic [10:0] g);
        if (g == 11'd0)
        begin
            return 1;
        end
        if (g > 11'd1024)
        begin
            return 1024;
        end
        return int'(g);
    endfunction

    // Round to nearest, clamp to 0..255
    function automatic logic [7:0] div9_round(input int s);
        int q;
        if (s <= 0)
        begin
            return 8'd0;
        end
        q = (s + 4) / 9;
        if (q > 255)
        begin
            q = 255;
        end
        return 8'(q);
    endfunction

    function automatic logic [7:0] chan_filter(input logic [8:0][23:0] tap, input int sh,
                                               input kmode_t m);
        int centre;
        int right;
        int total;
        int k;
        total = 0;
        for (k = 0; k < 9; k++)
        begin
            total += int'((tap[k] >> sh) & 24'hFF);
        end
        centre = int'((tap[4] >> sh) & 24'hFF);
        right  = int'((tap[5] >> sh) & 24'hFF);
        case (m)
            KM_IDENTITY: return 8'(centre);
            KM_MEAN:     return div9_round(total);
            KM_RIGHT:    return 8'(right);
            default:     return div9_round(18 * centre - total);
        endcase
    endfunction

    // Advance the filter model by one input beat
    task automatic conv_step(input logic act, input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, output bit emitted, output pix_res_t res);
        int unsigned      w;
        int unsigned      h;
        int unsigned      col;
        logic [23:0]      v;
        logic [23:0]      up2;
        logic [23:0]      up1;
        logic [8:0][23:0] tap;
        int               orow;
        int               ocol;
        int               rr;
        int               cc;
        int               ri;
        int               ci;
        bit               is_last;
        w = geom_eff(cur_width);
        h = geom_eff(cur_height);
        if (pos_col >= w)
        begin
            pos_col = 0;
        end
        col = pos_col;
        v = (act || pos_row >= h) ? 24'd0 : {r, g, b};
        up2 = line_b[col];
        up1 = line_a[col];
        line_b[col] = up1;
        line_a[col] = v;

        // shift the window left, new column on the right
        for (ri = 0; ri < 3; ri++)
        begin
            win[ri*3]   = win[ri*3+1];
            win[ri*3+1] = win[ri*3+2];
        end
        win[2] = up2;
        win[5] = up1;
        win[8] = v;

        emitted = (pos_row >= 2) || (pos_row == 1 && col >= 1);
        if (col >= 1)
        begin
            orow = int'(pos_row) - 1;
            ocol = int'(col) - 1;
        end
        else
        begin
            orow = int'(pos_row) - 2;
            ocol = int'(w) - 1;
        end

        pos_col = col + 1;
        if (pos_col >= w)
        begin
            pos_col = 0;
            if (pos_row < 2047)
            begin
                pos_row++;
            end
        end

        res = '0;
        if (!emitted)
        begin
            return;
        end

        // zero padding outside the frame
        for (ri = 0; ri < 3; ri++)
        begin
            for (ci = 0; ci < 3; ci++)
            begin
                rr = orow + ri - 1;
                cc = ocol + ci - 1;
                if (rr >= 0 && rr < int'(h) && cc >= 0 && cc < int'(w))
                begin
                    tap[ri*3+ci] = win[ri*3+ci];
                end
                else
                begin
                    tap[ri*3+ci] = 24'd0;
                end
            end
        end
        res.red   = chan_filter(tap, 16, cur_mode);
        res.green = chan_filter(tap, 8, cur_mode);
        res.blue  = chan_filter(tap, 0, cur_mode);

        is_last = pos_cnt >= w * h - 1;
        res.fe = is_last;
        if (is_last)
        begin
            pos_col = 0;
            pos_row = 0;
            pos_cnt = 0;
        end
        else
        begin
            pos_cnt = (pos_cnt + 1) & 32'hFFFFF;
        end
    endtask

    function automatic logic [7:0] rand_chan();
        int unsigned pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
        begin
            return 8'h00;
        end
        if (pick == 1)
        begin
            return 8'hFF;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Send one input beat, then predict what it causes
    task automatic push_beat(input logic act, input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input logic chk, input pix_res_t typed);
        int unsigned gap;
        bit          emitted;
        pix_res_t    res;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        red_in   <= r;
        green_in <= g;
        blue_in  <= b;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        n_in++;
        conv_step(act, r, g, b, emitted, res);
        if (chk)
        begin
            pixel_q.push_back(typed);
        end
        else if (emitted)
        begin
            pixel_q.push_back(res);
        end
    endtask

    // Register write, only once the pipeline has drained
    task automatic reg_write(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pixel_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        n_cfg++;
        case (idx)
            CFG_KERNEL_MODE:
            begin
                cur_mode = kmode_t'(data[1:0]);
            end
            CFG_IMAGE_WIDTH:
            begin
                cur_width = data;
                pos_col = 0;
                pos_row = 0;
                pos_cnt = 0;
            end
            CFG_IMAGE_HEIGHT:
            begin
                cur_height = data;
                pos_col = 0;
                pos_row = 0;
                pos_cnt = 0;
            end
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One frame: pixels, then the W+1 flush beats; cut > 0 stops early
    task automatic send_frame(input int unsigned w, input int unsigned h,
                              input int unsigned cut, output int unsigned sent);
        int unsigned count;
        int unsigned i;
        logic        act;
        count = w * h + w + 1;
        if (cut != 0)
        begin
            count = cut;
        end
        for (i = 0; i < count; i++)
        begin
            if (i < w * h)
            begin
                act = ($urandom_range(0, 15) == 0);
            end
            else
            begin
                act = ($urandom_range(0, 7) != 0);
            end
            push_beat(act, rand_chan(), rand_chan(), rand_chan(), 1'b0, '0);
        end
        sent = count;
    endtask

    function automatic plan_row_t beat_row(input logic act, input logic [7:0] r,
                                           input logic [7:0] g, input logic [7:0] b);
        plan_row_t row;
        row = '0;
        row.kind  = ROW_BEAT;
        row.act   = act;
        row.red   = r;
        row.green = g;
        row.blue  = b;
        return row;
    endfunction

    function automatic plan_row_t beat_chk(input logic act, input logic [7:0] r,
                                           input logic [7:0] g, input logic [7:0] b,
                                           input logic [7:0] er, input logic [7:0] eg,
                                           input logic [7:0] eb, input logic fe);
        plan_row_t row;
        row = beat_row(act, r, g, b);
        row.chk        = 1'b1;
        row.want.red   = er;
        row.want.green = eg;
        row.want.blue  = eb;
        row.want.fe    = fe;
        return row;
    endfunction

    function automatic plan_row_t reg_row(input logic [CFG_INDEX_BITS-1:0] idx,
                                          input logic [CFG_DATA_BITS-1:0] data);
        plan_row_t row;
        row = '0;
        row.kind = ROW_REG;
        row.idx  = idx;
        row.data = data;
        return row;
    endfunction

    // Output side: random stall per beat, compare in order
    initial
    begin
        pix_res_t exp_px;
        int unsigned stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 7);
            @(negedge clk);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
            begin
                @(posedge clk);
            end
            n_out++;
            if (frame_end === 1'b1)
            begin
                n_frames++;
            end
            if (pixel_q.size() == 0)
            begin
                note_fail($sformatf("output beat with nothing pending: rgb %h %h %h fe %b",
                                    red_out, green_out, blue_out, frame_end));
            end
            else
            begin
                exp_px = pixel_q.pop_front();
                if (red_out !== exp_px.red || green_out !== exp_px.green ||
                    blue_out !== exp_px.blue || frame_end !== exp_px.fe)
                begin
                    note_fail($sformatf("beat %0d: expected rgb %h %h %h fe %b, got %h %h %h fe %b",
                                        n_out, exp_px.red, exp_px.green, exp_px.blue, exp_px.fe,
                                        red_out, green_out, blue_out, frame_end));
                end
            end
        end
    end

    // Main sequence
    initial
    begin
        int unsigned i;
        int unsigned fw;
        int unsigned fh;
        int unsigned nfr;
        int unsigned cut;
        int unsigned sent;
        int unsigned n_rand;
        int unsigned f;
        logic [CFG_DATA_BITS-1:0] d;
        bit restart;
        plan_row_t row;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        action    = 1'b0;
        red_in    = '0;
        green_in  = '0;
        blue_in   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        no_idle   = 1'b0;
        err_cnt   = 0;
        n_in      = 0;
        n_out     = 0;
        n_frames  = 0;
        n_cfg     = 0;

        for (i = 0; i < 1024; i++)
        begin
            line_a[i] = '0;
            line_b[i] = '0;
        end
        win        = '0;
        pos_col    = 0;
        pos_row    = 0;
        pos_cnt    = 0;
        cur_mode   = KM_IDENTITY;
        cur_width  = RESET_WIDTH;
        cur_height = RESET_HEIGHT;

        // 3x2 frame with the kernel left at its reset value (identity)
        dir_plan.push_back(reg_row(CFG_IMAGE_WIDTH, 11'd3));
        dir_plan.push_back(reg_row(CFG_IMAGE_HEIGHT, 11'd2));
        dir_plan.push_back(beat_row(1'b0, 8'hFF, 8'hFF, 8'hFF));
        dir_plan.push_back(beat_row(1'b0, 8'h00, 8'h00, 8'h00));
        dir_plan.push_back(beat_row(1'b0, 8'h12, 8'h34, 8'h56));
        // drain inside the frame reads as black
        dir_plan.push_back(beat_row(1'b1, 8'hFF, 8'hFF, 8'hFF));
        dir_plan.push_back(beat_chk(1'b0, 8'h01, 8'h80, 8'hFE, 8'hFF, 8'hFF, 8'hFF, 1'b0));
        dir_plan.push_back(beat_chk(1'b0, 8'hA5, 8'h5A, 8'hC3, 8'h00, 8'h00, 8'h00, 1'b0));
        dir_plan.push_back(beat_chk(1'b1, 8'h00, 8'h00, 8'h00, 8'h12, 8'h34, 8'h56, 1'b0));
        dir_plan.push_back(beat_chk(1'b1, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0));
        // pixel after the last one of the frame is lost as padding
        dir_plan.push_back(beat_chk(1'b0, 8'h80, 8'h80, 8'h80, 8'h01, 8'h80, 8'hFE, 1'b0));
        dir_plan.push_back(beat_chk(1'b1, 8'h00, 8'h00, 8'h00, 8'hA5, 8'h5A, 8'hC3, 1'b1));

        // sharpen on 2x2, upper data bits of the mode write are don't-care
        dir_plan.push_back(reg_row(CFG_KERNEL_MODE, 11'h7FF));
        dir_plan.push_back(reg_row(CFG_IMAGE_WIDTH, 11'd2));
        dir_plan.push_back(reg_row(CFG_IMAGE_HEIGHT, 11'd2));
        dir_plan.push_back(beat_row(1'b0, 8'hFF, 8'hFF, 8'hFF));
        dir_plan.push_back(beat_row(1'b0, 8'h00, 8'h00, 8'h00));
        dir_plan.push_back(beat_row(1'b0, 8'h00, 8'hFF, 8'h10));
        dir_plan.push_back(beat_row(1'b0, 8'hFF, 8'h00, 8'h80));
        dir_plan.push_back(beat_row(1'b1, 8'h55, 8'hAA, 8'h55));
        dir_plan.push_back(beat_row(1'b1, 8'hAA, 8'h55, 8'hAA));
        dir_plan.push_back(beat_row(1'b1, 8'h00, 8'h00, 8'h00));

        // spare index ignored; width/height 0 act as 1; mean of a lone 255
        dir_plan.push_back(reg_row(CFG_SPARE_INDEX, 11'h7FF));
        dir_plan.push_back(reg_row(CFG_IMAGE_WIDTH, 11'd0));
        dir_plan.push_back(reg_row(CFG_IMAGE_HEIGHT, 11'd0));
        dir_plan.push_back(reg_row(CFG_KERNEL_MODE, 11'h7FD));
        dir_plan.push_back(beat_row(1'b0, 8'hFF, 8'hFF, 8'hFF));
        dir_plan.push_back(beat_row(1'b1, 8'h00, 8'h00, 8'h00));
        dir_plan.push_back(beat_chk(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'h1C, 8'h1C, 8'h1C, 1'b1));

        // right neighbor on 2x1: the last pixel sees the padding
        dir_plan.push_back(reg_row(CFG_KERNEL_MODE, 11'(KM_RIGHT)));
        dir_plan.push_back(reg_row(CFG_IMAGE_WIDTH, 11'd2));
        dir_plan.push_back(reg_row(CFG_IMAGE_HEIGHT, 11'd1));
        dir_plan.push_back(beat_row(1'b0, 8'h11, 8'h22, 8'h33));
        dir_plan.push_back(beat_row(1'b0, 8'h44, 8'h55, 8'h66));
        dir_plan.push_back(beat_row(1'b1, 8'h00, 8'h00, 8'h00));
        dir_plan.push_back(beat_chk(1'b1, 8'h00, 8'h00, 8'h00, 8'h44, 8'h55, 8'h66, 1'b0));
        dir_plan.push_back(beat_chk(1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1));

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part
        foreach (dir_plan[k])
        begin
            row = dir_plan[k];
            if (row.kind == ROW_REG)
            begin
                reg_write(row.idx, row.data);
            end
            else
            begin
                push_beat(row.act, row.red, row.green, row.blue, row.chk, row.want);
            end
        end

        // Geometry extremes, including out-of-range values; large frames are cut short
        for (i = 0; i < 4; i++)
        begin
            no_idle = ($urandom_range(0, 3) == 0);
            d = 11'($urandom_range(0, 2047));
            reg_write(CFG_KERNEL_MODE, d);
            reg_write(CFG_IMAGE_WIDTH, 11'(ext_w[i]));
            reg_write(CFG_IMAGE_HEIGHT, 11'(ext_h[i]));
            fw  = geom_eff(cur_width);
            fh  = geom_eff(cur_height);
            cut = (fw * fh > EXT_BEATS) ? EXT_BEATS : 0;
            send_frame(fw, fh, cut, sent);
        end

        // Random phases: mostly whole small frames, a few cut short
        n_rand  = 0;
        restart = 1'b1;
        while (n_rand < RAND_BEATS)
        begin
            no_idle = ($urandom_range(0, 3) == 0);
            d = 11'($urandom_range(0, 2047));
            reg_write(CFG_KERNEL_MODE, d);
            if ($urandom_range(0, 7) == 0)
            begin
                reg_write(CFG_SPARE_INDEX, 11'($urandom_range(0, 2047)));
            end
            if (restart || $urandom_range(0, 3) != 0)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    fw = $urandom_range(1, 40);
                    fh = $urandom_range(1, 12);
                end
                else
                begin
                    fw = $urandom_range(1, 8);
                    fh = $urandom_range(1, 6);
                end
                if ($urandom_range(0, 15) == 0)
                begin
                    fw = 0;
                end
                if ($urandom_range(0, 15) == 0)
                begin
                    fh = 0;
                end
                reg_write(CFG_IMAGE_WIDTH, 11'(fw));
                reg_write(CFG_IMAGE_HEIGHT, 11'(fh));
            end
            fw  = geom_eff(cur_width);
            fh  = geom_eff(cur_height);
            nfr = $urandom_range(1, 3);
            restart = 1'b0;
            for (f = 0; f < nfr; f++)
            begin
                cut = 0;
                if (f == nfr - 1 && $urandom_range(0, 7) == 0)
                begin
                    cut = $urandom_range(1, fw * fh + fw);
                    restart = 1'b1;
                end
                send_frame(fw, fh, cut, sent);
                n_rand += sent;
            end
        end

        // Drain and let the pipeline settle
        @(negedge clk);
        in_valid <= 1'b0;
        while (pixel_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4 * SETTLE_CYCLES) @(posedge clk);
        if (pixel_q.size() != 0)
        begin
            note_fail($sformatf("%0d output beats never arrived", pixel_q.size()));
        end

        $display("Summary: %0d input beats, %0d output beats, %0d frames closed, %0d reg writes",
                 n_in, n_out, n_frames, n_cfg);
        $display("Summary: all four kernels, frames up to 40x12, clamped geometry, %0d mismatches",
                 err_cnt);
        if (err_cnt == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: rgb_conv3x3_zero_pad.f
rtl/rcz_pkg.sv
rtl/rcz_line_buf.sv
rtl/rcz_filter.sv
rtl/rgb_conv3x3_zero_pad.sv
test/testbench.sv
